// ===== src/mbps_pkg.sv =====
// shared constants, register codes and types of the masked byte pattern search core
package mbps_pkg;

   // window and pattern geometry
   localparam int PATTERN_MAX = 32;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 6;
   localparam int COUNT_W     = 32;
   localparam int ADDR_W      = 32;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int POS_W       = $clog2(PATTERN_MAX);

   // register reset values
   localparam logic [31:0]    CARE_MASK_RESET = 32'hFFFF_FFFF;
   localparam logic [LEN_W-1:0] LENGTH_RESET  = 6'd1;

   // register codes, taken from address bits [5:3]
   typedef enum logic [2:0] {
      REG_PATTERN_0 = 3'd0,
      REG_PATTERN_1 = 3'd1,
      REG_PATTERN_2 = 3'd2,
      REG_PATTERN_3 = 3'd3,
      REG_CARE_MASK = 3'd4,
      REG_LENGTH    = 3'd5,
      REG_BASE      = 3'd6
   } reg_index_type;

   // bytes of the window or the pattern, byte 0 in the low bits
   typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] byte_vec_type;

   // compare settings handed to the window comparator
   typedef struct packed {
      byte_vec_type      pattern;
      logic [31:0]       care_mask;
      logic [LEN_W-1:0]  length;
   } cmp_cfg_type;

endpackage

// ===== src/mbps_window_cmp.sv =====
// parallel masked compare of the sliding window against the pattern
module mbps_window_cmp (
   input  mbps_pkg::byte_vec_type window,   // entry p holds the byte received p steps ago
   input  mbps_pkg::cmp_cfg_type  cfg,      // length must be 1 to PATTERN_MAX
   output logic                   match
);

   // pattern byte j lines up with window entry length-1-j
   always_comb begin
      logic [mbps_pkg::LEN_W-1:0] pos;
      logic                       in_use;
      logic                       care;
      match = 1'b1;
      for (int j = 0; j < mbps_pkg::PATTERN_MAX; j++) begin
         in_use = (mbps_pkg::LEN_W'(j) < cfg.length);
         care   = (j == 0) || cfg.care_mask[j];
         pos    = cfg.length - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(j);
         if (in_use && care &&
             (window[pos[mbps_pkg::POS_W-1:0]] != cfg.pattern[j])) begin
            match = 1'b0;
         end
      end
   end

endmodule

// ===== src/masked_byte_pattern_search_core.sv =====
// masked byte pattern search core: streaming byte scan with apb register port
//
// Bytes of a memory region stream in on req_, one per cycle unless stalled,
// the final byte marked by req_tlast. Every byte goes into an input register
// and is then shifted into a 32-byte window that is compared in parallel
// against the programmed pattern (byte 0 always compared, later bytes only
// where care_mask is set). The first matching offset is latched, and the
// final byte produces one transfer on rsp_: found in rsp_tuser, region_base
// plus offset in rsp_tdata (zero when nothing matched). The core takes one
// byte every cycle unless stalled; a result is registered once its last
// byte leaves the input register. req_tready drops only while a finished
// last byte sits in the input register and the previous result has not yet
// been taken. Registers lie at byte address 8*i on a 64-bit apb port and
// must be written between regions or while no byte is in flight.
module masked_byte_pattern_search_core (
   input  logic        clock,
   input  logic        reset,
   // byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] match_address
   output logic        rsp_tuser,    // [0] found
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [mbps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mbps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mbps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic [63:0] pat0_ff, pat1_ff, pat2_ff, pat3_ff;
   logic [31:0] care_ff;
   logic [mbps_pkg::LEN_W-1:0] length_ff;
   logic [mbps_pkg::ADDR_W-1:0] base_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // scan state
   mbps_pkg::byte_vec_type window_ff, window_in;
   logic [mbps_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         seen_ff, seen_in;
   logic [mbps_pkg::COUNT_W-1:0] offset_ff, offset_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff;
   logic [mbps_pkg::COUNT_W-1:0] rsp_offset_ff;

   logic                         csr_wr;
   mbps_pkg::reg_index_type      csr_idx;
   logic                         advance;
   logic                         req_xfer;
   logic [mbps_pkg::LEN_W-1:0]   len_use;
   mbps_pkg::cmp_cfg_type        cmp_cfg;
   logic                         win_match;
   logic [mbps_pkg::COUNT_W-1:0] len_ext;
   logic                         hit;

   // apb decode
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = mbps_pkg::reg_index_type'(csr_paddr[5:3]);

   always_comb begin
      unique case (csr_idx)
         mbps_pkg::REG_PATTERN_0: csr_prdata = pat0_ff;
         mbps_pkg::REG_PATTERN_1: csr_prdata = pat1_ff;
         mbps_pkg::REG_PATTERN_2: csr_prdata = pat2_ff;
         mbps_pkg::REG_PATTERN_3: csr_prdata = pat3_ff;
         mbps_pkg::REG_CARE_MASK: csr_prdata = {32'd0, care_ff};
         mbps_pkg::REG_LENGTH:    csr_prdata = {58'd0, length_ff};
         mbps_pkg::REG_BASE:      csr_prdata = {32'd0, base_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat0_ff   <= '0;
         pat1_ff   <= '0;
         pat2_ff   <= '0;
         pat3_ff   <= '0;
         care_ff   <= mbps_pkg::CARE_MASK_RESET;
         length_ff <= mbps_pkg::LENGTH_RESET;
         base_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            mbps_pkg::REG_PATTERN_0: pat0_ff   <= csr_pwdata;
            mbps_pkg::REG_PATTERN_1: pat1_ff   <= csr_pwdata;
            mbps_pkg::REG_PATTERN_2: pat2_ff   <= csr_pwdata;
            mbps_pkg::REG_PATTERN_3: pat3_ff   <= csr_pwdata;
            mbps_pkg::REG_CARE_MASK: care_ff   <= csr_pwdata[31:0];
            mbps_pkg::REG_LENGTH:    length_ff <= csr_pwdata[mbps_pkg::LEN_W-1:0];
            mbps_pkg::REG_BASE:      base_ff   <= csr_pwdata[mbps_pkg::ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: a held last byte waits only for the result register
   assign advance    = in_valid_ff && !(in_last_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // length in use: zero counts as one, capped at the window size
   always_comb begin
      if (length_ff == '0) begin
         len_use = mbps_pkg::LEN_W'(1);
      end else if (length_ff > mbps_pkg::LEN_W'(mbps_pkg::PATTERN_MAX)) begin
         len_use = mbps_pkg::LEN_W'(mbps_pkg::PATTERN_MAX);
      end else begin
         len_use = length_ff;
      end
   end

   // window after the held byte shifts in
   always_comb begin
      window_in = {window_ff[mbps_pkg::PATTERN_MAX-2:0], in_byte_ff};
   end

   assign cmp_cfg.pattern   = mbps_pkg::byte_vec_type'({pat3_ff, pat2_ff, pat1_ff, pat0_ff});
   assign cmp_cfg.care_mask = care_ff;
   assign cmp_cfg.length    = len_use;

   mbps_window_cmp u_cmp (
      .window (window_in),
      .cfg    (cmp_cfg),
      .match  (win_match)
   );

   // saturating byte count and first-match latch
   assign count_in = (count_ff == '1) ? count_ff : count_ff + mbps_pkg::COUNT_W'(1);
   assign len_ext  = mbps_pkg::COUNT_W'(len_use);
   assign hit      = !seen_ff && (count_in >= len_ext) && win_match;
   assign seen_in  = seen_ff || hit;
   assign offset_in = hit ? (count_in - len_ext) : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seen_ff  <= 1'b0;
      end else if (advance) begin
         if (in_last_ff) begin
            count_ff <= '0;
            seen_ff  <= 1'b0;
         end else begin
            count_ff <= count_in;
            seen_ff  <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         window_ff <= window_in;
         offset_ff <= offset_in;
      end
   end

   // result register
   assign rsp_valid_in = (advance && in_last_ff) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_found_ff  <= seen_in;
         rsp_offset_ff <= offset_in;
      end
   end

   // add on output; user keeps base stable while result pending; unenforced
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_found_ff ? (base_ff + rsp_offset_ff) : '0;

   // checks
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> (count_ff == '0) && !seen_ff)
      else $error("scan state not cleared after last byte");

   a_seen_has_bytes: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (count_ff != '0))
      else $error("match latched with empty byte count");

   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (offset_ff < count_ff))
      else $error("first offset beyond byte count");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a blocked result");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(advance && in_last_ff) |=> !rsp_valid_ff)
      else $error("result raised without a last byte");

endmodule
